// ----- hw/rtl/mandelbrot_pixel_engine_unit_defines.svh -----
// assertion macros for the mandelbrot pixel engine
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef MANDELBROT_PIXEL_ENGINE_UNIT_DEFINES_SVH
`define MANDELBROT_PIXEL_ENGINE_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define MPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// condition must hold in the following cycle
`define MPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/mpe_pkg.sv -----
// shared widths, codes, payload types and helper functions of the pixel engine
// no dependencies
package mpe_pkg;

    localparam int CoordBits   = 12;
    localparam int FracBits    = 28;
    localparam int WordBits    = 32;
    localparam int MulBits     = WordBits + 1;
    localparam int ProdBits    = 2 * MulBits;
    // a square of a word shifted down by the fraction bits
    localparam int SqBits      = 2 * WordBits - 1 - FracBits;
    localparam int ModBits     = SqBits + 1;
    localparam int CmpBits     = (ModBits > FracBits + 3) ? ModBits : FracBits + 3;
    // magnitude of window span times a coordinate
    localparam int MapBits     = WordBits + CoordBits;
    localparam int LevelBits   = SqBits + 8;
    localparam int DivBits     = (MapBits > LevelBits) ? MapBits : LevelBits;
    localparam int DenBits     = ModBits;
    localparam int DivCntBits  = $clog2(DivBits + 1);
    localparam int CfgIdxBits  = 3;

    localparam logic [CmpBits-1:0]  Limit4    = CmpBits'(4) << FracBits;
    localparam logic [WordBits-1:0] WordMax   = {1'b0, {(WordBits-1){1'b1}}};
    localparam logic [WordBits-1:0] WordMin   = {1'b1, {(WordBits-1){1'b0}}};
    localparam logic [7:0]          BlueLevel = 8'd128;

    localparam logic [CfgIdxBits-1:0] CfgRealLeft   = 3'd0;
    localparam logic [CfgIdxBits-1:0] CfgRealRight  = 3'd1;
    localparam logic [CfgIdxBits-1:0] CfgImagTop    = 3'd2;
    localparam logic [CfgIdxBits-1:0] CfgImagBottom = 3'd3;
    localparam logic [CfgIdxBits-1:0] CfgWidth      = 3'd4;
    localparam logic [CfgIdxBits-1:0] CfgHeight     = 3'd5;
    localparam logic [CfgIdxBits-1:0] CfgIterLimit  = 3'd6;

    typedef struct packed {
        logic [CoordBits-1:0] column;
        logic [CoordBits-1:0] row;
    } t_pixel_in;

    typedef struct packed {
        logic [CoordBits-1:0] out_column;
        logic [CoordBits-1:0] out_row;
        logic [7:0]           red_level;
        logic [7:0]           green_level;
        logic [7:0]           blue_level;
    } t_pixel_out;

    typedef struct packed {
        logic                      en;
        logic signed [MulBits-1:0] a;
        logic signed [MulBits-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DivBits-1:0] num;
        logic [DenBits-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DivBits-1:0] quot;
    } t_div_rsp;

    // clamp a wide signed value into one signed word
    function automatic logic signed [WordBits-1:0] sat_word(
        input logic signed [ProdBits-1:0] v
    );
        logic hi_zero;
        logic hi_one;
        hi_zero = ~|v[ProdBits-1:WordBits-1];
        hi_one  = &v[ProdBits-1:WordBits-1];
        if (hi_zero || hi_one) begin
            return v[WordBits-1:0];
        end else if (v[ProdBits-1]) begin
            return WordMin;
        end else begin
            return WordMax;
        end
    endfunction

    // 255 times a square, as a divider numerator
    function automatic logic [DivBits-1:0] level_num(input logic [SqBits-1:0] sq);
        logic [LevelBits-1:0] prod;
        prod = {sq, 8'd0} - LevelBits'(sq);
        return DivBits'(prod);
    endfunction

    function automatic logic [7:0] sat_level(input logic [DivBits-1:0] q);
        if (|q[DivBits-1:8]) begin
            return 8'hff;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

// ----- hw/rtl/mandelbrot_pixel_engine_unit.sv -----
// mandelbrot pixel engine top level: config registers, sequencer, result register
// depends on mpe_pkg, mpe_mul, mpe_div and the assertion macro header
// input channel i_in_valid / o_in_ready carries a pixel column and row; the
// output channel o_out_valid / i_out_ready returns the coordinate with red,
// green and a constant blue level. one pixel is in work at a time: o_in_ready
// is high only while the engine is idle.
// a pixel runs through the window mapping, the escape iterations (at most
// iteration_limit) and the two colour divisions, with DivBits = 44 by default;
// a zero modulus skips both colour divisions, and a zero limit skips the
// iterations too. each iteration is one pass through S_IT_B to S_IT_E over
// the one shared multiplier (z_r*z_i, n_r^2, n_i^2); the window mapping and
// both colour ratios go through the shared divider at one quotient bit per cycle.
// a finished result sits in the output register; the next pixel is accepted
// while it waits. if the receiver stalls and a second result is ready, the
// engine holds it and stays busy until the register frees.
// config is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data), to be
// written only while idle; the engine does not enforce it. unknown indexes are ignored.
// synchronous active-low reset loads the default window (-2..1, 1..-1),
// 640x480 and 100 iterations, and empties the engine and the output register.
`include "mandelbrot_pixel_engine_unit_defines.svh"

module mandelbrot_pixel_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mpe_pkg::t_pixel_in                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mpe_pkg::t_pixel_out                o_out_data,
    input  logic                               i_cfg_wr_en,
    input  logic [mpe_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  logic [mpe_pkg::WordBits-1:0]       i_cfg_data
);
    import mpe_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MAP_DIFF  = 4'd1;
    localparam logic [3:0] S_MAP_MUL_R = 4'd2;
    localparam logic [3:0] S_MAP_MUL_I = 4'd3;
    localparam logic [3:0] S_MAP_DIV_R = 4'd4;
    localparam logic [3:0] S_MAP_DIV_I = 4'd5;
    localparam logic [3:0] S_IT_A      = 4'd6;
    localparam logic [3:0] S_IT_B      = 4'd7;
    localparam logic [3:0] S_IT_C      = 4'd8;
    localparam logic [3:0] S_IT_D      = 4'd9;
    localparam logic [3:0] S_IT_E      = 4'd10;
    localparam logic [3:0] S_COL_R     = 4'd11;
    localparam logic [3:0] S_COL_RW    = 4'd12;
    localparam logic [3:0] S_COL_GW    = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    localparam logic [WordBits-1:0] RstRealLeft   = 32'he000_0000;
    localparam logic [WordBits-1:0] RstRealRight  = 32'h1000_0000;
    localparam logic [WordBits-1:0] RstImagTop    = 32'h1000_0000;
    localparam logic [WordBits-1:0] RstImagBottom = 32'hf000_0000;
    localparam logic [12:0]         RstWidth      = 13'd640;
    localparam logic [12:0]         RstHeight     = 13'd480;
    localparam logic [9:0]          RstIterLimit  = 10'd100;

    // config registers
    logic signed [WordBits-1:0] r_real_left, r_real_right, r_imag_top, r_imag_bottom;
    logic [12:0]                r_width, r_height;
    logic [9:0]                 r_limit;

    // sequencer and datapath
    logic [3:0]                   r_state, n_state;
    logic [CoordBits-1:0]         r_col, r_row;
    logic signed [MulBits-1:0]    r_diff;
    logic                         r_neg;
    logic signed [WordBits-1:0]   r_cr, r_ci, r_zr, r_zi, r_nr, r_ni;
    logic signed [2*WordBits-1:0] r_dif;
    logic [2*WordBits-1:0]        r_sq_r, r_sq_i, r_sq_nr;
    logic [ModBits-1:0]           r_m;
    logic [9:0]                   r_cnt;
    logic [7:0]                   r_red, r_green;
    logic                         r_out_valid;
    t_pixel_out                   r_out;

    t_mul_req                     mul_req;
    logic signed [ProdBits-1:0]   mul_p;
    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    logic                         in_fire;
    logic                         out_load;
    logic                         map_neg;
    logic signed [ProdBits-1:0]   map_mag;
    logic [DivBits-1:0]           map_num;
    logic [DenBits-1:0]           w_den, h_den;
    logic signed [WordBits-1:0]   map_base;
    logic signed [DivBits+1:0]    map_sum;
    logic signed [WordBits-1:0]   map_val;
    logic signed [ProdBits-1:0]   nr_wide, ni_wide;
    logic [ModBits-1:0]           mod_next;
    logic                         escape;
    logic [9:0]                   cnt_inc;
    logic [SqBits-1:0]            sq_r_top, sq_i_top;

    mpe_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_p)
    );

    mpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_left   <= RstRealLeft;
            r_real_right  <= RstRealRight;
            r_imag_top    <= RstImagTop;
            r_imag_bottom <= RstImagBottom;
            r_width       <= RstWidth;
            r_height      <= RstHeight;
            r_limit       <= RstIterLimit;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CfgRealLeft:   r_real_left   <= i_cfg_data;
                CfgRealRight:  r_real_right  <= i_cfg_data;
                CfgImagTop:    r_imag_top    <= i_cfg_data;
                CfgImagBottom: r_imag_bottom <= i_cfg_data;
                CfgWidth:      r_width       <= i_cfg_data[12:0];
                CfgHeight:     r_height      <= i_cfg_data[12:0];
                CfgIterLimit:  r_limit       <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // mapping: span*coord sign and magnitude, then corner +/- quotient
        map_neg  = mul_p[ProdBits-1];
        map_mag  = map_neg ? -mul_p : mul_p;
        map_num  = map_mag[DivBits-1:0];
        w_den    = (r_width == '0) ? DenBits'(1) : DenBits'(r_width);
        h_den    = (r_height == '0) ? DenBits'(1) : DenBits'(r_height);
        map_base = (r_state == S_MAP_DIV_R) ? r_real_left : r_imag_top;
        map_sum  = r_neg ? ((DivBits+2)'(map_base) - $signed((DivBits+2)'(div_rsp.quot)))
                         : ((DivBits+2)'(map_base) + $signed((DivBits+2)'(div_rsp.quot)));
        map_val  = sat_word(ProdBits'(map_sum));

        // one escape step
        nr_wide  = (ProdBits'(r_dif) >>> FracBits) + ProdBits'(r_cr);
        ni_wide  = (mul_p >>> (FracBits - 1)) + ProdBits'(r_ci);
        mod_next = ModBits'(r_sq_nr[2*WordBits-2:FracBits])
                 + ModBits'(mul_p[2*WordBits-2:FracBits]);
        escape   = CmpBits'(mod_next) > Limit4;
        cnt_inc  = r_cnt + 1'b1;

        sq_r_top = r_sq_r[2*WordBits-2:FracBits];
        sq_i_top = r_sq_i[2*WordBits-2:FracBits];
    end

    always_comb begin
        mul_req       = '0;
        div_req       = '0;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MAP_DIFF;
                end
            end
            S_MAP_DIFF: begin
                n_state = S_MAP_MUL_R;
            end
            S_MAP_MUL_R: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_diff;
                mul_req.b  = MulBits'(r_col);
                n_state    = S_MAP_MUL_I;
            end
            S_MAP_MUL_I: begin
                mul_req.en    = 1'b1;
                mul_req.a     = r_diff;
                mul_req.b     = MulBits'(r_row);
                div_req.start = 1'b1;
                div_req.num   = map_num;
                div_req.den   = w_den;
                n_state       = S_MAP_DIV_R;
            end
            S_MAP_DIV_R: begin
                div_req.start = div_rsp.done;
                div_req.num   = map_num;
                div_req.den   = h_den;
                if (div_rsp.done) begin
                    n_state = S_MAP_DIV_I;
                end
            end
            S_MAP_DIV_I: begin
                if (div_rsp.done) begin
                    n_state = (r_limit == '0) ? S_COL_R : S_IT_A;
                end
            end
            S_IT_A: begin
                // z starts at zero, so the cross product is zero too
                mul_req.en = 1'b1;
                mul_req.a  = MulBits'(r_zr);
                mul_req.b  = MulBits'(r_zi);
                n_state    = S_IT_B;
            end
            S_IT_B: begin
                n_state = S_IT_C;
            end
            S_IT_C: begin
                mul_req.en = 1'b1;
                mul_req.a  = MulBits'(r_nr);
                mul_req.b  = MulBits'(r_nr);
                n_state    = S_IT_D;
            end
            S_IT_D: begin
                mul_req.en = 1'b1;
                mul_req.a  = MulBits'(r_ni);
                mul_req.b  = MulBits'(r_ni);
                n_state    = S_IT_E;
            end
            S_IT_E: begin
                // cross product for the next step, dropped on escape
                mul_req.en = 1'b1;
                mul_req.a  = MulBits'(r_nr);
                mul_req.b  = MulBits'(r_ni);
                if (escape || (cnt_inc == r_limit)) begin
                    n_state = S_COL_R;
                end else begin
                    n_state = S_IT_B;
                end
            end
            S_COL_R: begin
                div_req.start = (r_m != '0);
                div_req.num   = level_num(sq_i_top);
                div_req.den   = r_m;
                n_state       = (r_m == '0) ? S_DONE : S_COL_RW;
            end
            S_COL_RW: begin
                div_req.start = div_rsp.done;
                div_req.num   = level_num(sq_r_top);
                div_req.den   = r_m;
                if (div_rsp.done) begin
                    n_state = S_COL_GW;
                end
            end
            S_COL_GW: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_col <= i_in_data.column;
                    r_row <= i_in_data.row;
                end
            end
            S_MAP_DIFF: begin
                r_diff <= MulBits'(r_real_right) - MulBits'(r_real_left);
            end
            S_MAP_MUL_R: begin
                r_diff <= MulBits'(r_imag_bottom) - MulBits'(r_imag_top);
            end
            S_MAP_MUL_I: begin
                r_neg <= map_neg;
            end
            S_MAP_DIV_R: begin
                if (div_rsp.done) begin
                    r_cr  <= map_val;
                    r_neg <= map_neg;
                end
            end
            S_MAP_DIV_I: begin
                if (div_rsp.done) begin
                    r_ci   <= map_val;
                    r_zr   <= '0;
                    r_zi   <= '0;
                    r_sq_r <= '0;
                    r_sq_i <= '0;
                    r_m    <= '0;
                    r_cnt  <= '0;
                end
            end
            S_IT_A: begin
                r_dif <= '0;
            end
            S_IT_B: begin
                r_nr <= sat_word(nr_wide);
                r_ni <= sat_word(ni_wide);
            end
            S_IT_D: begin
                r_sq_nr <= mul_p[2*WordBits-1:0];
            end
            S_IT_E: begin
                r_m <= mod_next;
                if (!escape) begin
                    r_zr   <= r_nr;
                    r_zi   <= r_ni;
                    r_sq_r <= r_sq_nr;
                    r_sq_i <= mul_p[2*WordBits-1:0];
                    r_dif  <= $signed(r_sq_nr) - $signed(mul_p[2*WordBits-1:0]);
                    r_cnt  <= cnt_inc;
                end
            end
            S_COL_R: begin
                if (r_m == '0) begin
                    r_red   <= '0;
                    r_green <= '0;
                end
            end
            S_COL_RW: begin
                if (div_rsp.done) begin
                    r_red <= sat_level(div_rsp.quot);
                end
            end
            S_COL_GW: begin
                if (div_rsp.done) begin
                    r_green <= sat_level(div_rsp.quot);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_out.out_column  <= r_col;
                    r_out.out_row     <= r_row;
                    r_out.red_level   <= r_red;
                    r_out.green_level <= r_green;
                    r_out.blue_level  <= BlueLevel;
                end
            end
            default: begin
            end
        endcase
    end

    `MPE_ASSERT_SAME(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `MPE_ASSERT_NEXT(a_one_pixel_in_work, i_clk, i_rst_n, in_fire, !o_in_ready)
    `MPE_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && !i_out_ready, (r_state == S_DONE) && r_out_valid)

endmodule

// ----- hw/rtl/mpe_mul.sv -----
// shared signed multiplier with a registered product
// depends on mpe_pkg
module mpe_mul (
    input  logic                               i_clk,
    input  mpe_pkg::t_mul_req                  i_req,
    output logic signed [mpe_pkg::ProdBits-1:0] o_prod
);
    import mpe_pkg::*;

    logic signed [ProdBits-1:0] r_prod;

    // product holds until the next issue
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= ProdBits'($signed(i_req.a)) * ProdBits'($signed(i_req.b));
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/mpe_div.sv -----
// unsigned restoring divider, one quotient bit per cycle
// depends on mpe_pkg
module mpe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpe_pkg::t_div_req i_req,
    output mpe_pkg::t_div_rsp o_rsp
);
    import mpe_pkg::*;

    logic [DivBits-1:0]    r_quot, n_quot;
    logic [DenBits-1:0]    r_rem, n_rem;
    logic [DenBits-1:0]    r_den;
    logic [DivCntBits-1:0] r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [DenBits:0]      rem_sh;
    logic [DenBits:0]      rem_sub;
    logic                  q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DivBits-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = ~rem_sub[DenBits];
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_cnt  = DivCntBits'(DivBits);
        end else if (r_cnt != '0) begin
            n_rem  = q_bit ? rem_sub[DenBits-1:0] : rem_sh[DenBits-1:0];
            // dividend shifts out the top while quotient bits fill the bottom
            n_quot = {r_quot[DivBits-2:0], q_bit};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == DivCntBits'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for mandelbrot_pixel_engine_unit: directed and random pixels
// with a fixed-point escape-time predictor; depends on mpe_pkg and the engine rtl
module tb;
    import mpe_pkg::*;

    localparam longint Unit         = 64'sd1 << FracBits;
    localparam longint EscapeBound  = 4 * Unit;
    localparam longint WordHi       = 64'sd2147483647;
    localparam longint WordLo       = -64'sd2147483648;
    localparam int     RxHoldCycles = 3000;
    localparam logic [CfgIdxBits-1:0] CfgUnusedIndex = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_pixel_in             in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_pixel_out            out_data;
    logic                  cfg_wr_en;
    logic [CfgIdxBits-1:0] cfg_index;
    logic [WordBits-1:0]   cfg_data;

    // window and limits as the engine should hold them
    longint win_real_left, win_real_right, win_imag_top, win_imag_bottom;
    longint div_width, div_height, iter_limit;

    t_pixel_out expected_pixels[$];
    int         mismatch_count = 0;
    int         tx_idle_pct = 8;
    int         rx_idle_pct = 8;
    int         hold_requests = 0;
    int         hold_served = 0;

    mandelbrot_pixel_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic longint clamp_word(input longint v);
        if (v > WordHi) begin
            return WordHi;
        end else if (v < WordLo) begin
            return WordLo;
        end
        return v;
    endfunction

    // division truncates toward zero, a zero divisor counts as one
    function automatic longint map_coord(input longint lo, input longint hi,
                                         input longint pos, input longint div);
        longint d;
        d = (div == 0) ? 1 : div;
        return clamp_word(lo + ((hi - lo) * pos) / d);
    endfunction

    function automatic logic [7:0] colour_share(input longint sq, input longint modulus);
        longint r;
        if (modulus == 0) begin
            return 8'd0;
        end
        r = (255 * sq) / modulus;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic t_pixel_out escape_colours(input t_pixel_in px);
        t_pixel_out res;
        longint     cr, ci, zr, zi, nr, ni, modulus;
        int         step;
        bit         escaped;
        cr = map_coord(win_real_left, win_real_right, longint'(px.column), div_width);
        ci = map_coord(win_imag_top, win_imag_bottom, longint'(px.row), div_height);
        zr = 0;
        zi = 0;
        modulus = 0;
        escaped = 1'b0;
        step = 0;
        while (!escaped && step < iter_limit) begin
            nr = clamp_word(((zr * zr - zi * zi) >>> FracBits) + cr);
            ni = clamp_word(((zr * zi) >>> (FracBits - 1)) + ci);
            modulus = ((nr * nr) >>> FracBits) + ((ni * ni) >>> FracBits);
            if (modulus > EscapeBound) begin
                escaped = 1'b1;
            end else begin
                zr = nr;
                zi = ni;
            end
            step++;
        end
        res.out_column  = px.column;
        res.out_row     = px.row;
        res.red_level   = colour_share((zi * zi) >>> FracBits, modulus);
        res.green_level = colour_share((zr * zr) >>> FracBits, modulus);
        res.blue_level  = BlueLevel;
        return res;
    endfunction

    // ---------------- drivers ----------------

    // called and returns at a falling edge, with the block idle
    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [WordBits-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            CfgRealLeft:   win_real_left   = longint'(signed'(data));
            CfgRealRight:  win_real_right  = longint'(signed'(data));
            CfgImagTop:    win_imag_top    = longint'(signed'(data));
            CfgImagBottom: win_imag_bottom = longint'(signed'(data));
            CfgWidth:      div_width       = longint'(data[12:0]);
            CfgHeight:     div_height      = longint'(data[12:0]);
            CfgIterLimit:  iter_limit      = longint'(data[9:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input longint rl, input longint rr, input longint it,
                              input longint ib, input longint w, input longint h,
                              input longint lim);
        write_reg(CfgRealLeft,   WordBits'(rl));
        write_reg(CfgRealRight,  WordBits'(rr));
        write_reg(CfgImagTop,    WordBits'(it));
        write_reg(CfgImagBottom, WordBits'(ib));
        write_reg(CfgWidth,      WordBits'(w));
        write_reg(CfgHeight,     WordBits'(h));
        write_reg(CfgIterLimit,  WordBits'(lim));
    endtask

    task automatic set_reset_config();
        set_config(-2 * Unit, Unit, Unit, -Unit, 640, 480, 100);
    endtask

    // starts and ends at a falling edge; valid stays high after the transaction
    task automatic send_pixel(input t_pixel_in px);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = px;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        expected_pixels.push_back(escape_colours(px));
        @(negedge i_clk);
    endtask

    task automatic send_xy(input int col, input int row);
        t_pixel_in px;
        px.column = CoordBits'(col);
        px.row    = CoordBits'(row);
        send_pixel(px);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // mostly inside the image, now and then anywhere in the coordinate range
    function automatic t_pixel_in random_pixel(input longint w, input longint h);
        t_pixel_in px;
        if ($urandom_range(0, 7) == 0) begin
            px.column = CoordBits'($urandom_range(0, 4095));
            px.row    = CoordBits'($urandom_range(0, 4095));
        end else begin
            px.column = CoordBits'($urandom_range(0, (w > 4095) ? 4095 : int'(w)));
            px.row    = CoordBits'($urandom_range(0, (h > 4095) ? 4095 : int'(h)));
        end
        return px;
    endfunction

    // ---------------- receiver and checker ----------------

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                out_ready = 1'b0;
                repeat (RxHoldCycles) @(negedge i_clk);
            end
            out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            if (mismatch_count < 200) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                if (mismatch_count < 200) begin
                    $display("%0t: unexpected transaction, expected none, actual %p",
                             $time, out_data);
                end
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_column",  want.out_column,  out_data.out_column);
                check_field("out_row",     want.out_row,     out_data.out_row);
                check_field("red_level",   12'(want.red_level),   12'(out_data.red_level));
                check_field("green_level", 12'(want.green_level), 12'(out_data.green_level));
                check_field("blue_level",  12'(want.blue_level),  12'(out_data.blue_level));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_values();
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(320, 240);
        send_xy(639, 479);
        send_xy(4095, 0);
        wait_idle();
    endtask

    // c is zero everywhere, so z stays at the origin
    task automatic test_zero_modulus();
        set_config(0, 0, 0, 0, 640, 480, 7);
        send_xy(0, 0);
        send_xy(123, 456);
        wait_idle();
    endtask

    task automatic test_zero_limit();
        set_config(-2 * Unit, Unit, Unit, -Unit, 640, 480, 32'hffff_fc00);
        send_xy(320, 240);
        send_xy(4095, 4095);
        wait_idle();
    endtask

    // only the upper bits are set, the divisors read as zero
    task automatic test_zero_divisor();
        set_config(-2 * Unit, Unit, Unit, -Unit, 32'hffff_e000, 32'hffff_e000, 10);
        send_xy(0, 0);
        send_xy(1, 1);
        send_xy(4095, 4095);
        wait_idle();
    endtask

    task automatic test_window_saturation();
        set_config(WordLo, WordHi, WordHi, WordLo, 1, 1, 20);
        send_xy(4095, 4095);
        send_xy(0, 0);
        send_xy(1, 1);
        wait_idle();
        set_config(WordHi, WordLo, WordLo, WordHi, 1, 1, 20);
        send_xy(4095, 4095);
        send_xy(2, 3);
        wait_idle();
    endtask

    task automatic test_unknown_index();
        set_reset_config();
        write_reg(CfgUnusedIndex, $urandom);
        send_xy(160, 120);
        send_xy(480, 360);
        wait_idle();
    endtask

    task automatic test_extreme_registers();
        set_config(-Unit / 4, Unit / 4, Unit / 4, -Unit / 4, 8191, 4096, 1023);
        send_xy(4095, 2048);
        send_xy(0, 0);
        wait_idle();
    endtask

    task automatic test_default_window(input int count);
        set_reset_config();
        repeat (count) send_pixel(random_pixel(640, 480));
        wait_idle();
    endtask

    task automatic test_random_windows(input int phases, input int count);
        longint re_mid, im_mid, half_re, half_im, w, h, lim;
        for (int p = 0; p < phases; p++) begin
            re_mid  = longint'($urandom_range(0, 671088640)) - 2 * Unit;
            im_mid  = longint'($urandom_range(0, 671088640)) - 335544320;
            half_re = 64'sd1 << $urandom_range(10, 30);
            half_im = 64'sd1 << $urandom_range(10, 30);
            w   = ($urandom_range(0, 9) == 0) ? 64'sd4096 : longint'($urandom_range(1, 400));
            h   = ($urandom_range(0, 9) == 0) ? 64'sd4096 : longint'($urandom_range(1, 400));
            lim = longint'($urandom_range(1, 128));
            // mirrored windows are as valid as ordinary ones
            if ($urandom_range(0, 1)) begin
                set_config(re_mid - half_re, re_mid + half_re, im_mid + half_im,
                           im_mid - half_im, w, h, lim);
            end else begin
                set_config(re_mid + half_re, re_mid - half_re, im_mid - half_im,
                           im_mid + half_im, w, h, lim);
            end
            repeat (count) send_pixel(random_pixel(w, h));
            wait_idle();
        end
    endtask

    task automatic test_noise_config(input int count);
        set_config(longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'(($urandom & 32'hffff_fc00) | $urandom_range(0, 160)));
        repeat (count) send_pixel(random_pixel(div_width, div_height));
        wait_idle();
    endtask

    // window inside the main cardioid: most pixels run to the limit
    task automatic test_deep_iterations(input int count);
        set_config(-Unit / 4, Unit / 4, Unit / 4, -Unit / 4, 64, 64, 1023);
        repeat (count) send_pixel(random_pixel(64, 64));
        wait_idle();
    endtask

    task automatic test_output_backpressure(input int count);
        set_reset_config();
        hold_requests++;
        repeat (count) send_pixel(random_pixel(640, 480));
        wait_idle();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        win_real_left   = -2 * Unit;
        win_real_right  = Unit;
        win_imag_top    = Unit;
        win_imag_bottom = -Unit;
        div_width       = 640;
        div_height      = 480;
        iter_limit      = 100;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_zero_modulus();
        test_zero_limit();
        test_zero_divisor();
        test_window_saturation();
        test_unknown_index();
        test_extreme_registers();

        test_default_window(120);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_windows(1, 100);
        tx_idle_pct = 8;
        rx_idle_pct = 8;
        test_random_windows(5, 100);
        test_noise_config(60);
        test_deep_iterations(6);
        test_output_backpressure(8);

        wait_idle();
        repeat (500) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
